/* sv/wss_pkg.sv */
package wss_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GEOM_W      = 4;
    localparam int SIZE_W      = 11;
    localparam int WEIGHT_W    = 16;
    localparam int BIAS_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int FRAC_SHIFT  = 14;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_W = 3'd0,
        CFG_KERNEL_H = 3'd1,
        CFG_STRIDE_X = 3'd2,
        CFG_STRIDE_Y = 3'd3,
        CFG_IMAGE_W  = 3'd4,
        CFG_IMAGE_H  = 3'd5,
        CFG_WEIGHT   = 3'd6,
        CFG_BIAS     = 3'd7
    } t_cfg_idx;

    localparam logic [GEOM_W-1:0]   RST_KERNEL_W = 4'd2;
    localparam logic [GEOM_W-1:0]   RST_KERNEL_H = 4'd2;
    localparam logic [GEOM_W-1:0]   RST_STRIDE_X = 4'd2;
    localparam logic [GEOM_W-1:0]   RST_STRIDE_Y = 4'd2;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_W  = 11'd1024;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_H  = 11'd1024;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 16'd16384;
    localparam logic [BIAS_W-1:0]   RST_BIAS     = 32'd0;

    // per-pixel classification handed from the front to the back
    typedef struct packed {
        logic row_first;
        logic sub_row;
        logic col_first;
        logic sub_col;
        logic emit;
        logic row_end;
        logic plane_end;
    } t_flags;

endpackage

/* sv/wss_front.sv */
module wss_front #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_KERNEL_W = 8,
    parameter int MAX_KERNEL_H = 8,
    localparam int XW  = $clog2(MAX_WIDTH),
    localparam int KWW = $clog2(MAX_KERNEL_W + 1),
    localparam int HSW = (MAX_KERNEL_H > 1) ? $clog2(MAX_KERNEL_H) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [wss_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_push,
    output logic [XW-1:0]                        o_x,
    output logic [HSW-1:0]                       o_slot_wr,
    output logic [HSW-1:0]                       o_slot_rd,
    output wss_pkg::t_flags                      o_flags,
    output logic [KWW-1:0]                       o_kernel_w,
    output logic signed [wss_pkg::WEIGHT_W-1:0]  o_weight,
    output logic signed [wss_pkg::BIAS_W-1:0]    o_bias
);
    import wss_pkg::*;

    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = XW + 1;
    localparam int HW  = YW + 1;
    localparam int KHW = $clog2(MAX_KERNEL_H + 1);
    localparam int PW  = ((WW > HW) ? WW : HW) + 2;
    localparam logic [HSW:0] SLOTS = (HSW + 1)'(MAX_KERNEL_H);

    logic [GEOM_W-1:0]          r_kernel_w, r_kernel_h, r_stride_x, r_stride_y;
    logic [SIZE_W-1:0]          r_image_w, r_image_h;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [BIAS_W-1:0]   r_bias;
    logic [XW-1:0]              r_x, n_x;
    logic [YW-1:0]              r_y, n_y;
    logic [GEOM_W-1:0]          r_cph, n_cph, r_rph, n_rph;
    logic [HSW-1:0]             r_slot, n_slot;

    logic [KWW-1:0]    kw;
    logic [KHW-1:0]    kh;
    logic [GEOM_W-1:0] sx, sy, cur_cph, cur_rph;
    logic [WW-1:0]     w;
    logic [HW-1:0]     h;
    logic [PW-1:0]     px, py, pw, ph, pkw, pkh, psx, psy;
    logic              col_ok, row_ok, last_col, last_row;
    logic [HSW:0]      s_ext, skh;

    always_comb begin
        if (r_kernel_w == '0) begin
            kw = KWW'(1);
        end else if (r_kernel_w > MAX_KERNEL_W) begin
            kw = KWW'(MAX_KERNEL_W);
        end else begin
            kw = KWW'(r_kernel_w);
        end
        if (r_kernel_h == '0) begin
            kh = KHW'(1);
        end else if (r_kernel_h > MAX_KERNEL_H) begin
            kh = KHW'(MAX_KERNEL_H);
        end else begin
            kh = KHW'(r_kernel_h);
        end
        if (r_image_w == '0) begin
            w = WW'(1);
        end else if (r_image_w > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_image_w);
        end
        if (r_image_h == '0) begin
            h = HW'(1);
        end else if (r_image_h > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(r_image_h);
        end
        sx = (r_stride_x == '0) ? GEOM_W'(1) : r_stride_x;
        sy = (r_stride_y == '0) ? GEOM_W'(1) : r_stride_y;
    end

    always_comb begin
        px  = PW'(r_x);
        py  = PW'(r_y);
        pw  = PW'(w);
        ph  = PW'(h);
        pkw = PW'(kw);
        pkh = PW'(kh);
        psx = PW'(sx);
        psy = PW'(sy);

        col_ok   = (px + PW'(1)) >= pkw;
        row_ok   = (py + PW'(1)) >= pkh;
        last_col = (px + PW'(1)) == pw;
        last_row = (py + PW'(1)) == ph;

        // phase restarts where the first window of a row or column ends
        cur_cph = ((px + PW'(1)) == pkw) ? '0 : r_cph;
        cur_rph = ((py + PW'(1)) == pkh) ? '0 : r_rph;

        o_flags.row_first = (r_y == '0);
        o_flags.sub_row   = (py >= pkh);
        o_flags.col_first = (r_x == '0);
        o_flags.sub_col   = (px >= pkw);
        o_flags.emit      = (pw >= pkw) && (ph >= pkh) && col_ok && row_ok &&
                            (cur_cph == '0) && (cur_rph == '0);
        // no further window start fits in the row / plane
        o_flags.row_end   = (px + psx) >= pw;
        o_flags.plane_end = ((px + psx) >= pw) && ((py + psy) >= ph);

        // ring slot of the row that leaves the column sum
        s_ext = {1'b0, r_slot};
        skh   = (HSW + 1)'(kh);
        if (s_ext >= skh) begin
            o_slot_rd = HSW'(s_ext - skh);
        end else begin
            o_slot_rd = HSW'(s_ext + SLOTS - skh);
        end
        o_slot_wr = r_slot;
        o_x       = r_x;

        n_cph = r_cph;
        if (col_ok) begin
            n_cph = (cur_cph == sx - GEOM_W'(1)) ? '0 : cur_cph + GEOM_W'(1);
        end
        n_x    = r_x + XW'(1);
        n_y    = r_y;
        n_rph  = r_rph;
        n_slot = r_slot;
        if (last_col) begin
            n_x = '0;
            if (row_ok) begin
                n_rph = (cur_rph == sy - GEOM_W'(1)) ? '0 : cur_rph + GEOM_W'(1);
            end
            if (last_row) begin
                n_y    = '0;
                n_slot = '0;
            end else begin
                n_y    = r_y + YW'(1);
                n_slot = ({1'b0, r_slot} == SLOTS - (HSW + 1)'(1)) ? '0 :
                         r_slot + HSW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_w <= RST_KERNEL_W;
            r_kernel_h <= RST_KERNEL_H;
            r_stride_x <= RST_STRIDE_X;
            r_stride_y <= RST_STRIDE_Y;
            r_image_w  <= RST_IMAGE_W;
            r_image_h  <= RST_IMAGE_H;
            r_weight   <= RST_WEIGHT;
            r_bias     <= RST_BIAS;
            r_x        <= '0;
            r_y        <= '0;
            r_cph      <= '0;
            r_rph      <= '0;
            r_slot     <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL_W: r_kernel_w <= i_cfg_data[GEOM_W-1:0];
                CFG_KERNEL_H: r_kernel_h <= i_cfg_data[GEOM_W-1:0];
                CFG_STRIDE_X: r_stride_x <= i_cfg_data[GEOM_W-1:0];
                CFG_STRIDE_Y: r_stride_y <= i_cfg_data[GEOM_W-1:0];
                CFG_IMAGE_W:  r_image_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_H:  r_image_h  <= i_cfg_data[SIZE_W-1:0];
                CFG_WEIGHT:   r_weight   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_BIAS:     r_bias     <= i_cfg_data[BIAS_W-1:0];
                default: ;
            endcase
            // geometry change restarts the plane
            if (t_cfg_idx'(i_cfg_index) != CFG_WEIGHT &&
                t_cfg_idx'(i_cfg_index) != CFG_BIAS) begin
                r_x    <= '0;
                r_y    <= '0;
                r_cph  <= '0;
                r_rph  <= '0;
                r_slot <= '0;
            end
        end else if (i_push) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_cph  <= n_cph;
            r_rph  <= n_rph;
            r_slot <= n_slot;
        end
    end

    assign o_kernel_w = kw;
    assign o_weight   = r_weight;
    assign o_bias     = r_bias;

`ifndef NO_ASSERTIONS
    a_x_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        px < pw) else $error("column position beyond image width");
    a_y_in_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        py < ph) else $error("row position beyond image height");
    a_slot_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_cfg_valid && last_col && last_row |=> r_slot == '0)
        else $error("row ring slot not rewound at plane end");
`endif

endmodule

/* sv/wss_queue.sv */
module wss_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import wss_pkg::*;

    localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]   r_mem [QUEUE_DEPTH];
    logic [PTW-1:0] r_wr, r_rd;
    logic [CNW-1:0] r_count;
    logic           push_ok, pop_ok;

    assign o_ready = (r_count != CNW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + CNW'(1);
                2'b01:   r_count <= r_count - CNW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNW'(QUEUE_DEPTH)) |-> r_wr == r_rd)
        else $error("queue pointers disagree with count");
`endif

endmodule

/* sv/wss_back.sv */
module wss_back #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_KERNEL_W = 8,
    parameter int MAX_KERNEL_H = 8,
    parameter int PIXEL_BITS   = 16,
    localparam int XW  = $clog2(MAX_WIDTH),
    localparam int KWW = $clog2(MAX_KERNEL_W + 1),
    localparam int HSW = (MAX_KERNEL_H > 1) ? $clog2(MAX_KERNEL_H) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    output logic                                 o_q_ready,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    input  logic [XW-1:0]                        i_x,
    input  logic [HSW-1:0]                       i_slot_wr,
    input  logic [HSW-1:0]                       i_slot_rd,
    input  wss_pkg::t_flags                      i_flags,
    input  logic [KWW-1:0]                       i_kernel_w,
    input  logic signed [wss_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic signed [wss_pkg::BIAS_W-1:0]    i_bias,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [wss_pkg::VALUE_W-1:0]          o_value,
    output logic                                 o_row_end,
    output logic                                 o_plane_end
);
    import wss_pkg::*;

    localparam int CSW  = PIXEL_BITS + $clog2(MAX_KERNEL_H);
    localparam int WSW  = CSW + $clog2(MAX_KERNEL_W);
    localparam int KIW  = (MAX_KERNEL_W > 1) ? $clog2(MAX_KERNEL_W) : 1;
    localparam int PRW  = WSW + WEIGHT_W;
    localparam int SHW  = PRW - FRAC_SHIFT;
    localparam int SUMW = ((SHW > BIAS_W) ? SHW : BIAS_W) + 1;
    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

    logic signed [PIXEL_BITS-1:0] r_hist [MAX_KERNEL_H][MAX_WIDTH];
    logic signed [CSW-1:0]        r_colsum [MAX_WIDTH];
    logic signed [CSW-1:0]        r_recent [MAX_KERNEL_W];
    logic signed [WSW-1:0]        r_win;

    logic                         en, issue;
    logic                         r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic signed [PIXEL_BITS-1:0] r_hist_rd, r_s1_pixel;
    logic signed [CSW-1:0]        r_cs_rd, r_s2_cs;
    logic [XW-1:0]                r_s1_x, r_s2_x;
    t_flags                       r_s1_flags, r_s2_flags;
    logic signed [WSW-1:0]        r_s3_win;
    logic                         r_s3_row_end, r_s3_plane_end;
    logic signed [PRW-1:0]        r_s4_prod;
    logic                         r_s4_row_end, r_s4_plane_end;
    logic [VALUE_W-1:0]           r_out_value;
    logic                         r_out_row_end, r_out_plane_end;

    logic signed [CSW-1:0]        cs_base, cs_sub, n_cs;
    logic signed [WSW-1:0]        win_base, win_sub, n_win;
    logic [KIW-1:0]               kidx;
    logic signed [SHW-1:0]        shifted;
    logic signed [SUMW-1:0]       sum;
    logic [SUMW-VALUE_W:0]        top_bits;
    logic [VALUE_W-1:0]           n_value;

    // whole pipeline moves together; the queue in front absorbs stalls
    assign en        = !r_out_v || i_ready;
    assign issue     = i_q_valid && en;
    assign o_q_ready = en;

    // row history: read the leaving row before this pixel lands
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_hist_rd                  <= r_hist[i_slot_rd][i_x];
            r_hist[i_slot_wr][i_x]     <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cs_rd <= r_colsum[i_x];
        end
        if (en && r_s1_v) begin
            r_colsum[r_s1_x] <= n_cs;
        end
    end

    always_comb begin
        // one-pixel-wide image: previous item's column sum is not yet in memory
        if (r_s1_flags.row_first) begin
            cs_base = '0;
        end else if (r_s2_v && r_s2_x == r_s1_x) begin
            cs_base = r_s2_cs;
        end else begin
            cs_base = r_cs_rd;
        end
        cs_sub = r_s1_flags.sub_row ? CSW'(r_hist_rd) : '0;
        n_cs   = cs_base + CSW'(r_s1_pixel) - cs_sub;

        kidx     = KIW'(i_kernel_w - KWW'(1));
        win_base = r_s2_flags.col_first ? '0 : r_win;
        win_sub  = r_s2_flags.sub_col ? WSW'(r_recent[kidx]) : '0;
        n_win    = win_base + WSW'(r_s2_cs) - win_sub;

        // floor shift, bias, saturate
        shifted  = $signed(r_s4_prod[PRW-1:FRAC_SHIFT]);
        sum      = SUMW'(shifted) + SUMW'(i_bias);
        top_bits = sum[SUMW-1:VALUE_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            n_value = sum[VALUE_W-1:0];
        end else if (sum[SUMW-1]) begin
            n_value = VAL_MIN;
        end else begin
            n_value = VAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_v) begin
            r_win       <= n_win;
            r_recent[0] <= r_s2_cs;
            for (int i = 1; i < MAX_KERNEL_W; i++) begin
                r_recent[i] <= r_recent[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_q_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v && r_s2_flags.emit;
            r_s4_v  <= r_s3_v;
            r_out_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x          <= i_x;
            r_s1_pixel      <= i_pixel;
            r_s1_flags      <= i_flags;
            r_s2_x          <= r_s1_x;
            r_s2_cs         <= n_cs;
            r_s2_flags      <= r_s1_flags;
            r_s3_win        <= n_win;
            r_s3_row_end    <= r_s2_flags.row_end;
            r_s3_plane_end  <= r_s2_flags.plane_end;
            r_s4_prod       <= r_s3_win * i_weight;
            r_s4_row_end    <= r_s3_row_end;
            r_s4_plane_end  <= r_s3_plane_end;
            r_out_value     <= n_value;
            r_out_row_end   <= r_s4_row_end;
            r_out_plane_end <= r_s4_plane_end;
        end
    end

    assign o_valid     = r_out_v;
    assign o_value     = r_out_value;
    assign o_row_end   = r_out_row_end;
    assign o_plane_end = r_out_plane_end;

`ifndef NO_ASSERTIONS
    a_plane_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_plane_end |-> r_out_row_end)
        else $error("plane end without row end");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s4_v) && $stable(r_s3_v))
        else $error("pipeline moved while output stalled");
`endif

endmodule

/* sv/window_sum_subsample.sv */
// Weighted sum pooling over one image plane. Pixels (signed Q8.8) arrive in
// raster order on the s_ stream; for every kernel_width x kernel_height window
// on the stride grid the block emits plane_bias + floor(plane_weight * sum / 2^14),
// saturated to 32 bits, when the window's bottom-right pixel has arrived.
// One pixel is taken per clock while the output is not stalled; a running column
// sum per image column (one read and one write per pixel into the column-sum and
// row-history memories) and a running sum across the last kernel_width columns
// keep that rate for any kernel size. Results pass registers s1 to s4 and out.
// m_tlast marks the last result of a plane, m_tuser the last of an output row.
// Writing any geometry register restarts the plane; write config only while the
// block is idle. A plane smaller than the kernel gives no results.
module window_sum_subsample #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_KERNEL_W = 8,
    parameter int MAX_KERNEL_H = 8,
    parameter int PIXEL_BITS   = 16,
    localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [TDW-1:0]                  s_tdata,   // [PIXEL_BITS-1:0] pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wss_pkg::VALUE_W-1:0]     m_tdata,   // [31:0] window_value
    output logic                            m_tuser,   // [0] row_end
    output logic                            m_tlast    // plane_end
);
    import wss_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int KWW = $clog2(MAX_KERNEL_W + 1);
    localparam int HSW = (MAX_KERNEL_H > 1) ? $clog2(MAX_KERNEL_H) : 1;
    localparam int QW  = $bits(t_flags) + 2 * HSW + XW + PIXEL_BITS;

    logic [XW-1:0]              f_x, q_x;
    logic [HSW-1:0]             f_slot_wr, f_slot_rd, q_slot_wr, q_slot_rd;
    t_flags                     f_flags, q_flags;
    logic [KWW-1:0]             kernel_w;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [BIAS_W-1:0]   bias;
    logic [PIXEL_BITS-1:0]      q_pixel;
    logic [QW-1:0]              q_in, q_out;
    logic                       q_ready, q_valid, q_pop, push;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = q_ready;
    assign push        = s_tvalid && q_ready;

    wss_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_KERNEL_W (MAX_KERNEL_W),
        .MAX_KERNEL_H (MAX_KERNEL_H)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_x         (f_x),
        .o_slot_wr   (f_slot_wr),
        .o_slot_rd   (f_slot_rd),
        .o_flags     (f_flags),
        .o_kernel_w  (kernel_w),
        .o_weight    (weight),
        .o_bias      (bias)
    );

    assign q_in = {f_flags, f_slot_rd, f_slot_wr, f_x, s_tdata[PIXEL_BITS-1:0]};

    wss_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {q_flags, q_slot_rd, q_slot_wr, q_x, q_pixel} = q_out;

    wss_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_KERNEL_W (MAX_KERNEL_W),
        .MAX_KERNEL_H (MAX_KERNEL_H),
        .PIXEL_BITS   (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_pop),
        .i_pixel     ($signed(q_pixel)),
        .i_x         (q_x),
        .i_slot_wr   (q_slot_wr),
        .i_slot_rd   (q_slot_rd),
        .i_flags     (q_flags),
        .i_kernel_w  (kernel_w),
        .i_weight    (weight),
        .i_bias      (bias),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_value     (m_tdata),
        .o_row_end   (m_tuser),
        .o_plane_end (m_tlast)
    );

endmodule
